// ===== src/qsj_pkg.sv =====
// Shared types, widths and helpers for the quad scaled Jacobian unit.
// Used by every module under src; depends on nothing else.
package qsj_pkg;

    // Coordinate and field widths
    localparam int FIELD_BITS = 16;
    localparam int COORD_BITS = 16;
    localparam int EW         = COORD_BITS + 1;      // edge component
    localparam int SW         = 2 * EW;              // square / cross product
    localparam int LW         = SW + 1;              // squared length, |det|
    localparam int LIMW       = 35;                  // degenerate limit register
    localparam int CMPW       = (LW > LIMW) ? LW : LIMW;
    localparam int SPLIT      = (LW + 1) / 2;        // low half of wide multiply
    localparam int HIW        = LW - SPLIT;
    localparam int PW         = 2 * LW;              // |a|^2 * |b|^2
    localparam int QBITS      = 16;                  // result magnitude bits
    localparam int QW         = 16;                  // quality field width
    localparam int RW         = PW + 2 * (QBITS - 1);
    localparam int TW         = PW + QBITS;
    localparam int CW         = RW + 2;
    localparam int BPW        = $clog2(QBITS);
    localparam int NLANE      = 4;
    // edge reg, four lane front stages, one stage per result bit, output reg
    localparam int NSTAGE     = 1 + 4 + QBITS + 1;

    localparam logic signed [QW-1:0] Q_ONE = {1'b0, {(QW-1){1'b1}}};

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] x0;
        logic signed [FIELD_BITS-1:0] y0;
        logic signed [FIELD_BITS-1:0] x1;
        logic signed [FIELD_BITS-1:0] y1;
        logic signed [FIELD_BITS-1:0] x2;
        logic signed [FIELD_BITS-1:0] y2;
        logic signed [FIELD_BITS-1:0] x3;
        logic signed [FIELD_BITS-1:0] y3;
    } in_t;

    typedef struct packed {
        logic signed [QW-1:0] quality;
        logic                 all_degenerate;
    } out_t;

    typedef struct packed {
        logic signed [EW-1:0] x;
        logic signed [EW-1:0] y;
    } edge_t;

    // State carried through the digit-by-digit root stages
    typedef struct packed {
        logic [RW-1:0]    r;      // remaining det^2*2^30 - m^2*P
        logic [TW-1:0]    t;      // m * P
        logic [PW-1:0]    p;      // |a|^2 * |b|^2
        logic [QBITS-1:0] m;      // magnitude found so far
        logic             skip;
        logic             neg;
    } root_t;

    typedef struct packed {
        logic                 skip;
        logic signed [QW-1:0] value;
    } lane_res_t;

    // Sign-extend the low COORD_BITS bits of a field
    function automatic logic signed [EW-1:0] coord(input logic [FIELD_BITS-1:0] field);
        coord = {{(EW - COORD_BITS){field[COORD_BITS-1]}}, field[COORD_BITS-1:0]};
    endfunction

endpackage

// ===== src/qsj_root_stage.sv =====
// One bit of the restoring search for the largest m with m^2*P <= det^2*2^30.
// Depends on qsj_pkg.
module qsj_root_stage (
    input  logic                        clk,
    input  logic                        en,
    input  logic [qsj_pkg::BPW-1:0]     bitpos,
    input  qsj_pkg::root_t              d,
    output qsj_pkg::root_t              q
);

    logic [qsj_pkg::CW-1:0]  trial;
    logic [qsj_pkg::CW-1:0]  p_shift;
    logic [qsj_pkg::BPW:0]   sh_t;
    logic [qsj_pkg::BPW:0]   sh_p;
    logic                    fit;
    qsj_pkg::root_t          q_next;
    qsj_pkg::root_t          q_reg;

    // (m + 2^k)^2 P - m^2 P = 2^(k+1) m P + 2^(2k) P
    always_comb
    begin
        sh_t    = {1'b0, bitpos} + {{qsj_pkg::BPW{1'b0}}, 1'b1};
        sh_p    = {bitpos, 1'b0};
        p_shift = qsj_pkg::CW'(d.p) << bitpos;
        trial   = (qsj_pkg::CW'(d.t) << sh_t) + (qsj_pkg::CW'(d.p) << sh_p);
        fit     = trial <= qsj_pkg::CW'(d.r);
        q_next  = d;
        if (fit)
        begin
            q_next.r = d.r - trial[qsj_pkg::RW-1:0];
            q_next.t = d.t + p_shift[qsj_pkg::TW-1:0];
            q_next.m = d.m | (qsj_pkg::QBITS'(1) << bitpos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== src/qsj_lane.sv =====
// One corner lane: edge products, lengths, det, wide products, then the
// bit-serial pipelined root search. Depends on qsj_pkg and qsj_root_stage.
module qsj_lane (
    input  logic                          clk,
    input  logic [qsj_pkg::QBITS+3:0]     en,
    input  qsj_pkg::edge_t                a,
    input  qsj_pkg::edge_t                b,
    input  logic [qsj_pkg::LIMW-1:0]      limit,
    output qsj_pkg::lane_res_t            res
);

    // stage 1: products
    logic signed [qsj_pkg::SW-1:0] sqax_next, sqay_next, sqbx_next, sqby_next;
    logic signed [qsj_pkg::SW-1:0] pab_next, pba_next;
    logic signed [qsj_pkg::SW-1:0] sqax_reg, sqay_reg, sqbx_reg, sqby_reg;
    logic signed [qsj_pkg::SW-1:0] pab_reg, pba_reg;

    assign sqax_next = a.x * a.x;
    assign sqay_next = a.y * a.y;
    assign sqbx_next = b.x * b.x;
    assign sqby_next = b.y * b.y;
    assign pab_next  = a.x * b.y;
    assign pba_next  = a.y * b.x;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sqax_reg <= sqax_next;
            sqay_reg <= sqay_next;
            sqbx_reg <= sqbx_next;
            sqby_reg <= sqby_next;
            pab_reg  <= pab_next;
            pba_reg  <= pba_next;
        end
    end

    // stage 2: lengths, det magnitude and sign, skip test
    logic [qsj_pkg::LW-1:0]        la_next, lb_next, dmag_next;
    logic signed [qsj_pkg::LW-1:0] det;
    logic                          neg2_next, skip2_next;
    logic [qsj_pkg::LW-1:0]        la_reg, lb_reg, dmag_reg;
    logic                          neg2_reg, skip2_reg;

    always_comb
    begin
        la_next    = {1'b0, sqax_reg} + {1'b0, sqay_reg};
        lb_next    = {1'b0, sqbx_reg} + {1'b0, sqby_reg};
        det        = {pab_reg[qsj_pkg::SW-1], pab_reg} - {pba_reg[qsj_pkg::SW-1], pba_reg};
        neg2_next  = det[qsj_pkg::LW-1];
        dmag_next  = neg2_next ? qsj_pkg::LW'(-det) : qsj_pkg::LW'(det);
        skip2_next = (qsj_pkg::CMPW'(la_next) <= qsj_pkg::CMPW'(limit)) ||
                     (qsj_pkg::CMPW'(lb_next) <= qsj_pkg::CMPW'(limit));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            la_reg    <= la_next;
            lb_reg    <= lb_next;
            dmag_reg  <= dmag_next;
            neg2_reg  <= neg2_next;
            skip2_reg <= skip2_next;
        end
    end

    // stage 3: partial products of la*lb and |det|^2
    logic [2*qsj_pkg::SPLIT-1:0]           pll_reg, dll_reg;
    logic [qsj_pkg::SPLIT+qsj_pkg::HIW-1:0] plh_reg, phl_reg, dlh_reg, dhl_reg;
    logic [2*qsj_pkg::HIW-1:0]             phh_reg, dhh_reg;
    logic                                  neg3_reg, skip3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pll_reg   <= la_reg[qsj_pkg::SPLIT-1:0] * lb_reg[qsj_pkg::SPLIT-1:0];
            plh_reg   <= la_reg[qsj_pkg::SPLIT-1:0] * lb_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT];
            phl_reg   <= la_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT] * lb_reg[qsj_pkg::SPLIT-1:0];
            phh_reg   <= la_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT]
                         * lb_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT];
            dll_reg   <= dmag_reg[qsj_pkg::SPLIT-1:0] * dmag_reg[qsj_pkg::SPLIT-1:0];
            dlh_reg   <= dmag_reg[qsj_pkg::SPLIT-1:0] * dmag_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT];
            dhl_reg   <= dmag_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT] * dmag_reg[qsj_pkg::SPLIT-1:0];
            dhh_reg   <= dmag_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT]
                         * dmag_reg[qsj_pkg::LW-1:qsj_pkg::SPLIT];
            neg3_reg  <= neg2_reg;
            skip3_reg <= skip2_reg;
        end
    end

    // stage 4: sum partials, set up the search
    logic [qsj_pkg::PW-1:0] p_sum, d_sum;
    qsj_pkg::root_t         root_next;
    qsj_pkg::root_t         root_reg;

    always_comb
    begin
        p_sum = qsj_pkg::PW'(pll_reg)
              + ((qsj_pkg::PW'(plh_reg) + qsj_pkg::PW'(phl_reg)) << qsj_pkg::SPLIT)
              + (qsj_pkg::PW'(phh_reg) << (2 * qsj_pkg::SPLIT));
        d_sum = qsj_pkg::PW'(dll_reg)
              + ((qsj_pkg::PW'(dlh_reg) + qsj_pkg::PW'(dhl_reg)) << qsj_pkg::SPLIT)
              + (qsj_pkg::PW'(dhh_reg) << (2 * qsj_pkg::SPLIT));
        root_next.r    = qsj_pkg::RW'(d_sum) << (2 * (qsj_pkg::QBITS - 1));
        root_next.t    = '0;
        root_next.p    = p_sum;
        root_next.m    = '0;
        root_next.skip = skip3_reg;
        root_next.neg  = neg3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            root_reg <= root_next;
        end
    end

    // one stage per result bit, MSB first
    qsj_pkg::root_t chain [qsj_pkg::QBITS+1];
    assign chain[0] = root_reg;

    for (genvar gi = 0; gi < qsj_pkg::QBITS; gi++)
    begin : g_bit
        qsj_root_stage u_stage (
            .clk    (clk),
            .en     (en[4+gi]),
            .bitpos (qsj_pkg::BPW'(qsj_pkg::QBITS - 1 - gi)),
            .d      (chain[gi]),
            .q      (chain[gi+1])
        );
    end

    // sign and saturation at +1
    logic [qsj_pkg::QBITS-1:0] m_fin;

    always_comb
    begin
        m_fin    = chain[qsj_pkg::QBITS].m;
        res.skip = chain[qsj_pkg::QBITS].skip;
        if (chain[qsj_pkg::QBITS].neg)
        begin
            res.value = qsj_pkg::QW'(-{1'b0, m_fin});
        end
        else if (m_fin[qsj_pkg::QBITS-1])
        begin
            res.value = qsj_pkg::Q_ONE;
        end
        else
        begin
            res.value = qsj_pkg::QW'(m_fin);
        end
    end

endmodule

// ===== src/qsj_merge.sv =====
// Merge of the four corner lanes: minimum over non-skipped corners and the
// all-degenerate flag. Depends on qsj_pkg.
module qsj_merge (
    input  qsj_pkg::lane_res_t [qsj_pkg::NLANE-1:0] lanes,
    output qsj_pkg::out_t                           result
);

    logic signed [qsj_pkg::QW-1:0] best;
    logic                          any;

    always_comb
    begin
        best = qsj_pkg::Q_ONE;
        any  = 1'b0;
        for (int i = 0; i < qsj_pkg::NLANE; i++)
        begin
            if (!lanes[i].skip)
            begin
                any = 1'b1;
                if (lanes[i].value < best)
                begin
                    best = lanes[i].value;
                end
            end
        end
        result.quality        = best;
        result.all_degenerate = !any;
    end

endmodule

// ===== src/quad_scaled_jacobian_unit.sv =====
// Top level of the quad scaled Jacobian unit: edge register, four corner
// lanes, merge and output register. Depends on qsj_pkg, qsj_lane, qsj_merge.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one quad (four vertices,
//   counter-clockwise). Output channel out_valid/out_ready/out_data returns
//   one item per quad: the minimum corner scaled Jacobian in Q1.15 and the
//   all-degenerate flag, in input order.
//   cfg_we/cfg_data write the degenerate limit; write it only while idle.
//   Pipeline from acceptance to out_valid: one edge register, four stages
//   of products and wide multiplies, sixteen stages of the bit-per-stage
//   root search (one result bit each), one output register. Throughput is
//   one quad per cycle when not stalled; four corners in parallel lanes.
//   Each pipeline stage has its own valid bit and advances when the stage
//   after it is empty or moving, so a stalled receiver only halts the
//   stages behind the waiting result and bubbles still close up; in_ready
//   drops only once every stage is full.
//   Reset clears all valid bits and the limit (to zero); no clearing pass.
module quad_scaled_jacobian_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  qsj_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output qsj_pkg::out_t                out_data,
    input  logic                         cfg_we,
    input  logic [qsj_pkg::LIMW-1:0]     cfg_data
);

    localparam int NS = qsj_pkg::NSTAGE;

    // configuration register
    logic [qsj_pkg::LIMW-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    // per-stage valid bits and ready chain
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   rdy;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];

    // edge vectors
    qsj_pkg::edge_t e0_reg, e1_reg, e2_reg, e3_reg;
    logic signed [qsj_pkg::EW-1:0] cx0, cy0, cx1, cy1, cx2, cy2, cx3, cy3;

    assign cx0 = qsj_pkg::coord(in_data.x0);
    assign cy0 = qsj_pkg::coord(in_data.y0);
    assign cx1 = qsj_pkg::coord(in_data.x1);
    assign cy1 = qsj_pkg::coord(in_data.y1);
    assign cx2 = qsj_pkg::coord(in_data.x2);
    assign cy2 = qsj_pkg::coord(in_data.y2);
    assign cx3 = qsj_pkg::coord(in_data.x3);
    assign cy3 = qsj_pkg::coord(in_data.y3);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            e0_reg.x <= cx1 - cx0;
            e0_reg.y <= cy1 - cy0;
            e1_reg.x <= cx2 - cx1;
            e1_reg.y <= cy2 - cy1;
            e2_reg.x <= cx2 - cx3;
            e2_reg.y <= cy2 - cy3;
            e3_reg.x <= cx3 - cx0;
            e3_reg.y <= cy3 - cy0;
        end
    end

    // corner lanes
    qsj_pkg::lane_res_t [qsj_pkg::NLANE-1:0] lane_res;
    logic [qsj_pkg::QBITS+3:0]               lane_en;

    assign lane_en = rdy[qsj_pkg::QBITS+4:1];

    qsj_lane u_lane0 (
        .clk (clk), .en (lane_en), .a (e0_reg), .b (e3_reg),
        .limit (limit_reg), .res (lane_res[0])
    );
    qsj_lane u_lane1 (
        .clk (clk), .en (lane_en), .a (e0_reg), .b (e1_reg),
        .limit (limit_reg), .res (lane_res[1])
    );
    qsj_lane u_lane2 (
        .clk (clk), .en (lane_en), .a (e2_reg), .b (e1_reg),
        .limit (limit_reg), .res (lane_res[2])
    );
    qsj_lane u_lane3 (
        .clk (clk), .en (lane_en), .a (e2_reg), .b (e3_reg),
        .limit (limit_reg), .res (lane_res[3])
    );

    // merge and output register
    qsj_pkg::out_t merged;
    qsj_pkg::out_t out_reg;

    qsj_merge u_merge (
        .lanes  (lane_res),
        .result (merged)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            out_reg <= merged;
        end
    end

    assign out_data = out_reg;

endmodule
